// ===== hw/rtl/frustum_plane_extraction_assert.svh =====
// Assertion macros for the frustum plane extraction block.
// Expects clk and arst_n in the scope of each use.
`ifndef FRUSTUM_PLANE_EXTRACTION_ASSERT_SVH
`define FRUSTUM_PLANE_EXTRACTION_ASSERT_SVH
`ifndef SYNTHESIS
`define FPE_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
`define FPE_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define FPE_ASSERT_IMP(lbl, ante, cons)
`define FPE_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== hw/rtl/fpe_pkg.sv =====
// Shared types and constants for the frustum plane extraction block.
// No dependencies.
package fpe_pkg;
	localparam int FRAC_BITS  = 16;
	localparam int NUM_PLANES = 6;
	localparam int DCNT_W     = $clog2(FRAC_BITS + 34);
	localparam logic [2:0]  LAST_PLANE = 3'(NUM_PLANES - 1);
	localparam logic [1:0]  W_COMP     = 2'd3;
	localparam logic [31:0] W_LIMIT    = 32'h8000_0000;
	localparam logic [31:0] N_MAX_POS  = 32'd131071;
	localparam logic [31:0] N_MAX_NEG  = 32'd131072;

	typedef enum logic [2:0] {
		S_IDLE, S_LOAD, S_NORM, S_SQ, S_SQRT, S_DLOAD, S_DIV, S_EMIT
	} state_t;

	typedef struct packed {
		logic store;
		logic plane_first;
		logic plane_load;
		logic norm_en;
		logic sq_en;
		logic sqrt_en;
		logic div_load;
		logic div_en;
		logic div_store;
		logic emit;
		logic plane_next;
	} cmd_t;

	typedef struct packed {
		logic zero;
		logic norm_done;
		logic sq_done;
		logic sqrt_done;
		logic div_done;
		logic comp_last;
		logic plane_last;
	} sts_t;
endpackage

// ===== hw/rtl/fpe_ctrl.sv =====
// Sequencer for the frustum plane extraction block.
// Depends on fpe_pkg.
module fpe_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          finish,
	input  fpe_pkg::sts_t sts,
	output fpe_pkg::cmd_t cmd,
	output logic          busy
);
	import fpe_pkg::*;

	state_t state_q, state_nx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nx;
		end
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			S_IDLE: begin
				if (start && finish) state_nx = S_LOAD;
			end
			S_LOAD: state_nx = S_NORM;
			S_NORM: begin
				if (sts.zero) state_nx = S_EMIT;
				else if (sts.norm_done) state_nx = S_SQ;
			end
			S_SQ: begin
				if (sts.sq_done) state_nx = S_SQRT;
			end
			S_SQRT: begin
				if (sts.sqrt_done) state_nx = S_DLOAD;
			end
			S_DLOAD: state_nx = S_DIV;
			S_DIV: begin
				if (sts.div_done) state_nx = sts.comp_last ? S_EMIT : S_DLOAD;
			end
			S_EMIT: state_nx = sts.plane_last ? S_IDLE : S_LOAD;
			default: state_nx = S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: begin
				cmd.store = start;
				cmd.plane_first = start && finish;
			end
			S_LOAD: cmd.plane_load = 1'b1;
			S_NORM: cmd.norm_en = !sts.zero && !sts.norm_done;
			S_SQ: cmd.sq_en = 1'b1;
			S_SQRT: cmd.sqrt_en = 1'b1;
			S_DLOAD: cmd.div_load = 1'b1;
			S_DIV: begin
				cmd.div_store = sts.div_done;
				cmd.div_en = !sts.div_done;
			end
			S_EMIT: begin
				cmd.emit = 1'b1;
				cmd.plane_next = !sts.plane_last;
			end
			default: cmd = '0;
		endcase
	end

	assign busy = (state_q != S_IDLE);
endmodule

// ===== hw/rtl/fpe_dp.sv =====
// Datapath: row store, plane sums, normalize, squares, square root, long division.
// Depends on fpe_pkg.
module fpe_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  fpe_pkg::cmd_t       cmd,
	output fpe_pkg::sts_t       sts,
	input  logic [1:0]          row_index,
	input  logic signed [31:0]  elem0,
	input  logic signed [31:0]  elem1,
	input  logic signed [31:0]  elem2,
	input  logic signed [31:0]  elem3,
	output logic                result_valid,
	output logic [2:0]          plane_index,
	output logic signed [17:0]  normal_x,
	output logic signed [17:0]  normal_y,
	output logic signed [17:0]  normal_z,
	output logic signed [31:0]  offset_w,
	output logic                degenerate,
	output logic                last_plane
);
	import fpe_pkg::*;

	logic [31:0]       store_q [4][4];
	logic [2:0]        pi_q;
	logic [32:0]       mag_c [4];
	logic              neg_c [4];
	logic [32:0]       max_c;
	logic [32:0]       mag3_q;
	logic              neg_q [4];
	logic [32:0]       ms_q [3];
	logic [32:0]       m_q;
	logic signed [5:0] k_q;
	logic [1:0]        sq_cnt_q;
	logic [61:0]       prod_q;
	logic [63:0]       sum_q;
	logic [63:0]       x_q;
	logic [63:0]       res_q;
	logic [63:0]       bit_q;
	logic [4:0]        sqrt_cnt_q;
	logic [63:0]       sq_t;
	logic [1:0]        ci_q;
	logic [31:0]       r_q;
	logic [31:0]       q_q;
	logic [2:0]        feed_q;
	logic [DCNT_W-1:0] dcnt_q;
	logic [32:0]       r2;
	logic              ge;
	logic [32:0]       qn;
	logic [31:0]       len;
	logic [31:0]       qsat;
	logic [17:0]       n_q [3];
	logic [31:0]       w_q;
	logic signed [6:0] fk;

	always_ff @(posedge clk) begin
		if (cmd.store) begin
			store_q[row_index][0] <= elem0;
			store_q[row_index][1] <= elem1;
			store_q[row_index][2] <= elem2;
			store_q[row_index][3] <= elem3;
		end
	end

	always_comb begin
		logic signed [32:0] a, b, c;
		for (int j = 0; j < 4; j++) begin
			a = 33'($signed(store_q[3][j]));
			b = 33'($signed(store_q[pi_q[2:1]][j]));
			c = pi_q[0] ? a - b : a + b;
			neg_c[j] = c[32];
			mag_c[j] = c[32] ? 33'(-c) : 33'(c);
		end
		max_c = mag_c[0];
		if (mag_c[1] > max_c) max_c = mag_c[1];
		if (mag_c[2] > max_c) max_c = mag_c[2];
	end

	// plane sums and normalization
	always_ff @(posedge clk) begin
		if (cmd.plane_first) begin
			pi_q <= '0;
		end else if (cmd.plane_next) begin
			pi_q <= pi_q + 3'd1;
		end
		if (cmd.plane_load) begin
			for (int j = 0; j < 4; j++) neg_q[j] <= neg_c[j];
			for (int j = 0; j < 3; j++) ms_q[j] <= mag_c[j];
			mag3_q <= mag_c[3];
			m_q <= max_c;
			k_q <= '0;
		end else if (cmd.norm_en) begin
			if (m_q[32:31] != 2'b00) begin
				m_q <= m_q >> 1;
				for (int j = 0; j < 3; j++) ms_q[j] <= ms_q[j] >> 1;
				k_q <= k_q - 6'sd1;
			end else begin
				m_q <= m_q << 1;
				for (int j = 0; j < 3; j++) ms_q[j] <= ms_q[j] << 1;
				k_q <= k_q + 6'sd1;
			end
		end
	end

	// sum of squares, one multiply per cycle, then bitwise square root
	assign sq_t = res_q + bit_q;

	always_ff @(posedge clk) begin
		if (cmd.plane_load) begin
			sq_cnt_q <= '0;
		end else if (cmd.sq_en) begin
			sq_cnt_q <= sq_cnt_q + 2'd1;
			if (sq_cnt_q != 2'd3) begin
				prod_q <= ms_q[sq_cnt_q][30:0] * ms_q[sq_cnt_q][30:0];
			end
			if (sq_cnt_q == 2'd0) begin
				sum_q <= '0;
			end else begin
				sum_q <= sum_q + 64'(prod_q);
			end
			if (sq_cnt_q == 2'd3) begin
				x_q <= sum_q + 64'(prod_q);
				res_q <= '0;
				bit_q <= 64'd1 << 62;
				sqrt_cnt_q <= '0;
			end
		end else if (cmd.sqrt_en) begin
			if (x_q >= sq_t) begin
				x_q <= x_q - sq_t;
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
			sqrt_cnt_q <= sqrt_cnt_q + 5'd1;
		end
	end

	// restoring long division with sticky saturation of the quotient
	assign len = res_q[31:0];
	assign fk = 7'(FRAC_BITS) + 7'(k_q);
	assign r2 = {r_q, feed_q[2]};
	assign ge = (r2 >= {1'b0, len});
	assign qn = {q_q, ge};

	always_comb begin
		if (ci_q == W_COMP) begin
			qsat = q_q;
		end else if (neg_q[ci_q]) begin
			qsat = (q_q > N_MAX_NEG) ? N_MAX_NEG : q_q;
		end else begin
			qsat = (q_q > N_MAX_POS) ? N_MAX_POS : q_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.plane_load) begin
			ci_q <= '0;
		end else if (cmd.div_load) begin
			q_q <= '0;
			if (ci_q == W_COMP) begin
				r_q <= 32'(mag3_q >> 3);
				feed_q <= mag3_q[2:0];
				dcnt_q <= DCNT_W'(7'sd3 + fk);
			end else begin
				r_q <= 32'(ms_q[ci_q] >> 1);
				feed_q <= {ms_q[ci_q][0], 2'b00};
				dcnt_q <= DCNT_W'(FRAC_BITS + 1);
			end
		end else if (cmd.div_en) begin
			r_q <= ge ? 32'(r2 - {1'b0, len}) : r2[31:0];
			q_q <= (qn > {1'b0, W_LIMIT}) ? W_LIMIT : qn[31:0];
			feed_q <= feed_q << 1;
			dcnt_q <= dcnt_q - DCNT_W'(1);
		end else if (cmd.div_store) begin
			ci_q <= ci_q + 2'd1;
			if (ci_q == W_COMP) begin
				if (neg_q[3]) w_q <= 32'(-q_q);
				else w_q <= (q_q > W_LIMIT - 32'd1) ? W_LIMIT - 32'd1 : q_q;
			end else begin
				n_q[ci_q] <= neg_q[ci_q] ? 18'(-qsat) : qsat[17:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			plane_index <= pi_q;
			last_plane <= (pi_q == LAST_PLANE);
			degenerate <= sts.zero;
			normal_x <= sts.zero ? '0 : n_q[0];
			normal_y <= sts.zero ? '0 : n_q[1];
			normal_z <= sts.zero ? '0 : n_q[2];
			offset_w <= sts.zero ? '0 : w_q;
		end
	end

	always_comb begin
		sts.zero = (m_q == '0);
		sts.norm_done = (m_q[32:31] == 2'b00) && m_q[30];
		sts.sq_done = (sq_cnt_q == 2'd3);
		sts.sqrt_done = (sqrt_cnt_q == 5'd31);
		sts.div_done = (dcnt_q == '0);
		sts.comp_last = (ci_q == W_COMP);
		sts.plane_last = (pi_q == LAST_PLANE);
	end
endmodule

// ===== hw/rtl/frustum_plane_extraction.sv =====
// Top level of the frustum plane extraction block.
// Depends on fpe_pkg, fpe_ctrl, fpe_dp and frustum_plane_extraction_assert.svh.
//
// Usage:
// - An item (one matrix row: row_index, elem0..elem3, finish) is taken at a
//   rising edge with start high and busy low. A row without finish is stored
//   and busy stays low.
// - A row with finish is stored, then six planes (left, right, bottom, top,
//   near, far) are formed from rows 0..3. busy is high until the last plane
//   has been handed to the output register.
// - Each plane result shows for one cycle with result_valid high; the sixth
//   carries last_plane. The receiver cannot hold results off.
// - Per plane: load, normalize, multiply/accumulate of the squares, 32
//   square-root steps, three normal divisions and an offset division, then
//   emit. A degenerate plane has only load, normalize check and emit. The
//   square root is bit-serial and one divider is shared by all divisions.
// - Reset clears the sequencer and result_valid; stored rows are undefined
//   until written.
module frustum_plane_extraction (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         row_index,
	input  logic signed [31:0] elem0,
	input  logic signed [31:0] elem1,
	input  logic signed [31:0] elem2,
	input  logic signed [31:0] elem3,
	input  logic               finish,
	output logic               result_valid,
	output logic [2:0]         plane_index,
	output logic signed [17:0] normal_x,
	output logic signed [17:0] normal_y,
	output logic signed [17:0] normal_z,
	output logic signed [31:0] offset_w,
	output logic               degenerate,
	output logic               last_plane
);
	import fpe_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fpe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.finish (finish),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	fpe_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.row_index    (row_index),
		.elem0        (elem0),
		.elem1        (elem1),
		.elem2        (elem2),
		.elem3        (elem3),
		.result_valid (result_valid),
		.plane_index  (plane_index),
		.normal_x     (normal_x),
		.normal_y     (normal_y),
		.normal_z     (normal_z),
		.offset_w     (offset_w),
		.degenerate   (degenerate),
		.last_plane   (last_plane)
	);

`include "frustum_plane_extraction_assert.svh"

	`FPE_ASSERT_NXT(a_finish_busy, start && !busy && finish, busy)
	`FPE_ASSERT_NXT(a_last_single, result_valid && last_plane, !result_valid)
	`FPE_ASSERT_IMP(a_degen_zero, result_valid && degenerate, {normal_x, normal_y, normal_z, offset_w} == '0)
	`FPE_ASSERT_IMP(a_last_index, result_valid && last_plane, plane_index == LAST_PLANE)
endmodule
